### sv/bda_pkg.sv
// Shared types and constants for the button debounce and auto-repeat unit.
package bda_pkg;

  localparam int unsigned NumButtonsDefault = 4;
  localparam int unsigned PinWidth          = 4;
  localparam int unsigned IndexWidth        = 3;
  localparam int unsigned TickWidth         = 15;
  localparam int unsigned CfgIndexWidth     = 2;

  localparam logic                 PressedLevelReset = 1'b0;
  localparam logic [TickWidth-1:0] FirstRepeatReset  = 15'd100;
  localparam logic [TickWidth-1:0] HoldRepeatReset   = 15'd25;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_PRESSED_LEVEL = 2'd0,
    CFG_FIRST_REPEAT  = 2'd1,
    CFG_HOLD_REPEAT   = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef struct packed {
    logic                 pressed_level;
    logic [TickWidth-1:0] first_repeat;
    logic [TickWidth-1:0] hold_repeat;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic clear;
    logic level;
  } btn_ctrl_t;

  typedef struct packed {
    logic                pressed_event;
    logic [PinWidth-1:0] stable_levels;
  } out_word_t;

endpackage

### sv/bda_if.sv
// Valid/ready channel interfaces for the input and result words.
interface bda_in_if import bda_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [PinWidth-1:0]   pin_levels;
  logic [IndexWidth-1:0] button_index;

  modport source (output valid, output action, output pin_levels, output button_index,
                  input ready);
  modport sink (input valid, input action, input pin_levels, input button_index,
                output ready);
endinterface

interface bda_out_if import bda_pkg::*;;
  logic                valid;
  logic                ready;
  logic                pressed_event;
  logic [PinWidth-1:0] stable_levels;

  modport source (output valid, output pressed_event, output stable_levels, input ready);
  modport sink (input valid, input pressed_event, input stable_levels, output ready);
endinterface

### sv/bda_button.sv
// Per-button three-sample debouncer with auto-repeat countdown and event flag.
module bda_button import bda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  btn_ctrl_t ctrl_i,
  input  cfg_t      cfg_i,
  output logic      stable_d_o,
  output logic      flag_q_o
);

  logic                 newest_q, newest_d;
  logic                 middle_q, middle_d;
  logic                 oldest_q, oldest_d;
  logic                 stable_q, stable_d;
  logic                 flag_q, flag_d;
  logic [TickWidth-1:0] count_q, count_d;
  logic                 settled;

  // The new sample settles the button when it matches the two it pushes along.
  assign settled = (ctrl_i.level == newest_q) && (ctrl_i.level == middle_q);

  always_comb begin
    newest_d = newest_q;
    middle_d = middle_q;
    oldest_d = oldest_q;
    stable_d = stable_q;
    flag_d   = flag_q;
    count_d  = count_q;
    if (ctrl_i.tick) begin
      oldest_d = middle_q;
      middle_d = newest_q;
      newest_d = ctrl_i.level;
      if (settled) begin
        if (stable_q != ctrl_i.level) begin
          stable_d = ctrl_i.level;
          if (ctrl_i.level == cfg_i.pressed_level) begin
            flag_d  = 1'b1;
            count_d = cfg_i.first_repeat;
          end
        end else if (ctrl_i.level == cfg_i.pressed_level) begin
          // Decrementing to zero or below fires; that is a count of one or zero now.
          if (count_q <= TickWidth'(1)) begin
            flag_d  = 1'b1;
            count_d = cfg_i.hold_repeat;
          end else begin
            count_d = count_q - TickWidth'(1);
          end
        end
      end
    end else if (ctrl_i.clear) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= 1'b0;
      middle_q <= 1'b0;
      oldest_q <= 1'b0;
      stable_q <= 1'b0;
      flag_q   <= 1'b0;
      count_q  <= '0;
    end else begin
      newest_q <= newest_d;
      middle_q <= middle_d;
      oldest_q <= oldest_d;
      stable_q <= stable_d;
      flag_q   <= flag_d;
      count_q  <= count_d;
    end
  end

  assign stable_d_o = stable_d;
  assign flag_q_o   = flag_q;

endmodule

### sv/bda_outbuf.sv
// Two-entry result buffer that decouples the input side from output stalls.
module bda_outbuf import bda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_word_t word_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output out_word_t word_o
);

  out_word_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign word_o  = entry_q[rd_ptr_q];

endmodule

### sv/button_debounce_autorepeat_unit.sv
// Top level of the multi-button debouncer with auto-repeat event flags.
//
//   Channel   Dir   Payload                                   Handshake
//   in_i      in    action, pin_levels[3:0], button_index[2:0] valid/ready
//   out_o     out   pressed_event, stable_levels[3:0]          valid/ready
//   cfg       in    cfg_we_i, cfg_idx_i[1:0], cfg_data_i[14:0] write enable only
//
// Every accepted word updates the button state in the cycle it is accepted and
// produces exactly one result word; out_o shows it once older results are taken.
// A word can be accepted every cycle; the two-entry result buffer holds up to
// two finished results, so in_i.ready drops only while both entries wait.
// Reset clears all debounce history, stable levels, flags and countdowns, and
// loads the configuration registers with their defaults (active-low pressed,
// first repeat after 100 ticks, then every 25 ticks).
module button_debounce_autorepeat_unit import bda_pkg::*; #(
  parameter int unsigned NumButtons = NumButtonsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  bda_in_if.sink                   in_i,
  bda_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_idx_i,
  input  logic [TickWidth-1:0]     cfg_data_i
);

  cfg_t                  cfg_q, cfg_d;
  logic                  accept;
  logic                  is_tick;
  logic                  is_query;
  logic                  buf_full;
  logic [NumButtons-1:0] stable_next;
  logic [NumButtons-1:0] flag_now;
  logic [NumButtons-1:0] query_sel;
  logic [PinWidth-1:0]   stable_packed;
  out_word_t             result;
  out_word_t             head_word;

  // Configuration registers; writes to unused indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_PRESSED_LEVEL: cfg_d.pressed_level = cfg_data_i[0];
        CFG_FIRST_REPEAT:  cfg_d.first_repeat  = cfg_data_i;
        CFG_HOLD_REPEAT:   cfg_d.hold_repeat   = cfg_data_i;
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressed_level <= PressedLevelReset;
      cfg_q.first_repeat  <= FirstRepeatReset;
      cfg_q.hold_repeat   <= HoldRepeatReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_i.ready = !buf_full;
  assign accept     = in_i.valid && in_i.ready;
  assign is_tick    = accept && (action_e'(in_i.action) == ACT_TICK);
  assign is_query   = accept && (action_e'(in_i.action) == ACT_QUERY);

  // One debounce cell per button. Buttons beyond the pin field see level 0.
  for (genvar b = 0; b < NumButtons; b++) begin : g_button
    btn_ctrl_t ctrl;
    logic      level;

    if (b < PinWidth) begin : g_pin
      assign level = in_i.pin_levels[b];
    end else begin : g_nopin
      assign level = 1'b0;
    end

    assign query_sel[b] = (in_i.button_index == IndexWidth'(b));
    assign ctrl.tick    = is_tick;
    assign ctrl.clear   = is_query && query_sel[b];
    assign ctrl.level   = level;

    bda_button u_button (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cfg_i      (cfg_q),
      .stable_d_o (stable_next[b]),
      .flag_q_o   (flag_now[b])
    );
  end

  // Only the first four buttons appear in the result.
  for (genvar p = 0; p < PinWidth; p++) begin : g_pack
    if (p < NumButtons) begin : g_used
      assign stable_packed[p] = stable_next[p];
    end else begin : g_unused
      assign stable_packed[p] = 1'b0;
    end
  end

  // An index past the last button selects nothing, so the query reads zero.
  assign result.pressed_event = is_query && |(flag_now & query_sel);
  assign result.stable_levels = stable_packed;

  bda_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .word_i  (result),
    .full_o  (buf_full),
    .valid_o (out_o.valid),
    .pop_i   (out_o.valid && out_o.ready),
    .word_o  (head_word)
  );

  assign out_o.pressed_event = head_word.pressed_event;
  assign out_o.stable_levels = head_word.stable_levels;

endmodule
